// ===== hw/rtl/ups_pkg.sv =====
// ----------------------------------------------------------------------------
// ups_pkg
// Shared types and constants of the unique pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ups_pkg;

  // Pattern register file geometry
  localparam int REG_BYTES       = 32;
  localparam int REG_WORD_W      = 64;
  localparam int MAX_PATTERN_DEF = 32;
  localparam int LEN_W           = 6;
  localparam int CFG_IDX_W       = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

  // Section characteristics bits
  localparam int FLAG_EXECUTE_BIT = 29;
  localparam int FLAG_READ_BIT    = 30;
  localparam int FLAG_DISCARD_BIT = 25;

  // Excluded section name heads, first character in the low byte
  localparam logic [31:0] NAME_PAGE = 32'h4547_4150;
  localparam logic [31:0] NAME_INIT = 32'h5449_4E49;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_AMBIGUOUS  = 2'd2,
    ST_BAD_LENGTH = 2'd3
  } ups_status_t;

  // Pattern configuration as seen by the datapath
  typedef struct packed {
    logic [8*REG_BYTES-1:0] pattern;
    logic [LEN_W-1:0]       length;
    logic                   length_ok;
  } ups_cfg_t;

  // Per-item control from the input stage
  typedef struct packed {
    logic go;
    logic last;
  } ups_step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ups_cfg.sv =====
// ----------------------------------------------------------------------------
// ups_cfg
// Pattern and length registers written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ups_cfg
  import ups_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [REG_WORD_W-1:0] cfg_data,
  output ups_cfg_t                   cfg
);

  localparam int CMP = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

  logic [REG_WORD_W-1:0] pattern_word [4];
  logic [LEN_W-1:0]      pattern_length;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) pattern_word[i] <= '0;
      pattern_length <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WORD0:  pattern_word[0] <= cfg_data;
        REG_WORD1:  pattern_word[1] <= cfg_data;
        REG_WORD2:  pattern_word[2] <= cfg_data;
        REG_WORD3:  pattern_word[3] <= cfg_data;
        REG_LENGTH: pattern_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Length is usable when non-zero and within the compare width
  always_comb begin
    cfg.pattern   = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};
    cfg.length    = pattern_length;
    cfg.length_ok = (pattern_length != '0) && (pattern_length <= LEN_W'(CMP));
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ups_match.sv =====
// ----------------------------------------------------------------------------
// ups_match
// Byte window of the current section and the parallel pattern compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ups_match
  import ups_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ups_step_t   step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        section_start,
  input  wire logic [31:0] section_flags,
  input  wire logic [31:0] section_name_head,
  input  wire ups_cfg_t    cfg,
  output logic             hit
);

  localparam int CMP    = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int CW     = (FILL_W > LEN_W) ? FILL_W : LEN_W;
  localparam int SH_W   = $clog2(CMP + 1);

  logic [7:0]        window      [MAX_PATTERN];
  logic [7:0]        window_next [MAX_PATTERN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_next;
  logic              section_ok;
  logic              section_ok_next;
  logic              eligible;
  logic              shift_en;
  logic              fill_ok;
  logic [8*CMP-1:0]  rev;
  logic [8*CMP-1:0]  aligned;
  logic [SH_W-1:0]   sh;
  logic [CMP-1:0]    byte_ok;

  // Section eligibility from characteristics and name head
  assign eligible = section_flags[FLAG_EXECUTE_BIT] && section_flags[FLAG_READ_BIT] &&
                    !section_flags[FLAG_DISCARD_BIT] &&
                    (section_name_head != NAME_PAGE) && (section_name_head != NAME_INIT);

  always_comb begin
    section_ok_next = section_start ? eligible : section_ok;
    fill_base       = section_start ? '0 : fill;
    fill_next       = fill_base;
    if (fill_base != FILL_W'(MAX_PATTERN)) fill_next = fill_base + 1'b1;
  end

  assign shift_en = step.go && section_ok_next;

  // Newest byte enters at entry 0
  always_comb begin
    window_next[0] = data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) window_next[i] = window[i-1];
  end

  // Window payload, no reset needed: reads are gated by the fill count
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < MAX_PATTERN; i++) window[i] <= window_next[i];
    end
  end

  // Fill count and section flag; cleared after the last byte of a scan
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      section_ok <= 1'b0;
    end else if (step.go) begin
      if (step.last) begin
        fill       <= '0;
        section_ok <= 1'b0;
      end else begin
        section_ok <= section_ok_next;
        if (section_start || section_ok_next) fill <= section_ok_next ? fill_next : '0;
      end
    end
  end

  // Align oldest of the last length bytes with pattern byte 0
  always_comb begin
    for (int i = 0; i < CMP; i++) rev[8*i +: 8] = window_next[CMP-1-i];
  end

  assign sh      = SH_W'(CMP) - cfg.length[SH_W-1:0];
  assign aligned = rev >> {sh, 3'b000};

  always_comb begin
    for (int k = 0; k < CMP; k++) begin
      byte_ok[k] = (aligned[8*k +: 8] == cfg.pattern[8*k +: 8]) ||
                   (LEN_W'(k) >= cfg.length);
    end
  end

  assign fill_ok = CW'(fill_next) >= CW'(cfg.length);
  assign hit     = shift_en && cfg.length_ok && fill_ok && (&byte_ok);

endmodule

`default_nettype wire

// ===== hw/rtl/ups_result.sv =====
// ----------------------------------------------------------------------------
// ups_result
// Match bookkeeping over a scan and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ups_result
  import ups_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ups_step_t   step,
  input  wire logic        hit,
  input  wire logic [63:0] byte_address,
  input  wire ups_cfg_t    cfg,
  output logic             res_valid,
  input  wire logic        res_ready,
  output ups_status_t      res_status,
  output logic [63:0]      res_address
);

  logic        found;
  logic        ambiguous;
  logic [63:0] found_address;
  logic        found_next;
  logic        ambiguous_next;
  logic [63:0] found_address_next;

  // Flags including the current byte
  always_comb begin
    found_next         = found || hit;
    ambiguous_next     = ambiguous || (hit && found);
    found_address_next = found_address;
    if (hit && !found) begin
      found_address_next = byte_address - 64'(cfg.length) + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found         <= 1'b0;
      ambiguous     <= 1'b0;
      found_address <= '0;
    end else if (step.go) begin
      if (step.last) begin
        found         <= 1'b0;
        ambiguous     <= 1'b0;
        found_address <= '0;
      end else begin
        found         <= found_next;
        ambiguous     <= ambiguous_next;
        found_address <= found_address_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step.go && step.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go && step.last) begin
      res_address <= '0;
      if (!cfg.length_ok) begin
        res_status <= ST_BAD_LENGTH;
      end else if (ambiguous_next) begin
        res_status <= ST_AMBIGUOUS;
      end else if (found_next) begin
        res_status  <= ST_FOUND;
        res_address <= found_address_next;
      end else begin
        res_status <= ST_NOT_FOUND;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/unique_pattern_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// unique_pattern_scanner_unit
// Searches a sectioned image byte stream for a pattern that must occur once.
// ----------------------------------------------------------------------------
// Usage:
//   Program the pattern words and the length on the cfg channel while idle.
//   Feed image bytes on the s_ stream: s_tuser flags the first byte of a
//   section (its characteristics and name head travel with that byte), and
//   s_tlast marks the final byte of the scan.
//   One result per scan leaves on the m_ stream: m_tuser carries the status,
//   m_tdata the start address of a unique match (zero otherwise).
// Throughput: one byte per cycle while no last byte is held. Each byte is
//   registered on entry, then shifted into the window and compared against
//   the whole pattern as it moves on; the window update is the loop that sets this rate.
// Result: the result register loads as the last byte leaves the input register.
// Stall: bytes keep flowing while a result waits; only a further last byte
//   holds at the input register until m_tready takes the pending result.
// Reset: clears the pattern registers, the scan state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_pattern_scanner_unit
  import ups_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // data_byte[7:0], byte_address[71:8], section_flags[103:72],
  // section_name_head[135:104]
  input  wire logic [135:0]          s_tdata,
  input  wire logic [0:0]            s_tuser,  // section_start[0]
  input  wire logic                  s_tlast,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  output logic [63:0]                m_tdata,  // match_address[63:0]
  output logic [1:0]                 m_tuser,  // scan_status[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [REG_WORD_W-1:0] cfg_data
);

  ups_cfg_t    cfg;
  ups_step_t   step;
  ups_status_t res_status;

  logic         in_valid;
  logic         in_last;
  logic         in_start;
  logic [7:0]   in_data;
  logic [63:0]  in_address;
  logic [31:0]  in_flags;
  logic [31:0]  in_name;
  logic         hit;

  ups_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Held item moves on unless it is a last byte and a result is still pending
  assign step.go   = in_valid && (!in_last || !m_tvalid || m_tready);
  assign step.last = in_last;
  assign s_tready  = !in_valid || step.go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step.go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data    <= s_tdata[7:0];
      in_address <= s_tdata[71:8];
      in_flags   <= s_tdata[103:72];
      in_name    <= s_tdata[135:104];
      in_start   <= s_tuser[0];
      in_last    <= s_tlast;
    end
  end

  ups_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .data_byte         (in_data),
    .section_start     (in_start),
    .section_flags     (in_flags),
    .section_name_head (in_name),
    .cfg               (cfg),
    .hit               (hit)
  );

  ups_result u_result (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .hit          (hit),
    .byte_address (in_address),
    .cfg          (cfg),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready),
    .res_status   (res_status),
    .res_address  (m_tdata)
  );

  assign m_tuser = res_status;

  // Only a found result carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_FOUND)) |-> (m_tdata == 64'd0))
    else $error("non-zero address on a failed scan");

  // A last byte that moves on always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (step.go && step.last) |=> m_tvalid)
    else $error("result missing after last byte");

  // Input only stalls behind a held last byte and a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_last && m_tvalid))
    else $error("input stalled without cause");

endmodule

`default_nettype wire
